// ----- hdl/gf2_matrix_multiply_macros.svh -----
`ifndef GF2_MATRIX_MULTIPLY_MACROS_SVH
`define GF2_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define GF2MM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gf2mm assertion failed");

// next-cycle implication
`define GF2MM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gf2mm assertion failed");

`endif

// ----- hdl/gf2mm_pkg.sv -----
package gf2mm_pkg;

   localparam int DIM_W = 7;
   localparam int IDX_W = 6;
   localparam int ROW_W = 64;

   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] CSR_ROWS_A     = 2'd0;
   localparam logic [1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [1:0] CSR_COLS_B     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_A,
      ST_ACC,
      ST_OUT
   } state_type;

   // zero acts as 1, above the limit saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- hdl/gf2_matrix_multiply.sv -----
// channel   dir  handshake                 tdata / tuser / tlast
// req       in   req_tvalid / req_tready   load_idx, row_bits / op / -
// rsp       out  rsp_tvalid / rsp_tready   result_index, result_bits / - / last
// csr       in   csr_we                    csr_index, csr_wdata
//
// A load item is written to its row memory when it is accepted. During a compute,
// one B row is read per cycle from the single read port of the B memory and XORed
// into the accumulator.
// Result rows go through an output register; a stalled rsp side holds the
// sequencer in its output state. req_tready is low while a compute runs.
// Reset is synchronous; the row memories are not cleared.
`include "gf2_matrix_multiply_macros.svh"

module gf2_matrix_multiply #(
   parameter int MAX_DIM = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // load_idx[5:0], row_bits[69:6], zero pad
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // result_index[5:0], result_bits[69:6], zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = gf2mm_pkg::DIM_W;
   localparam int IW = gf2mm_pkg::IDX_W;
   localparam int RW = gf2mm_pkg::ROW_W;
   localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);

   gf2mm_pkg::state_type state_ff, state_in;
   logic [DW-1:0] rows_ff, rows_in;
   logic [DW-1:0] inner_ff, inner_in;
   logic [DW-1:0] cols_ff, cols_in;
   logic [IW-1:0] r_ff, r_in;
   logic [DW-1:0] k_ff, k_in;
   logic [IW-1:0] pk_ff, pk_in;
   logic [RW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_index_ff, rsp_index_in;
   logic [RW-1:0] rsp_bits_ff, rsp_bits_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [IW-1:0] load_idx;
   logic [RW-1:0] row_bits;
   logic          req_fire, idx_ok, a_we, b_we;
   logic          a_re, b_re;
   logic [AW-1:0] a_raddr, b_raddr;
   logic [RW-1:0] a_q, b_q;
   logic [RW-1:0] col_mask;
   logic          last_row;

   assign load_idx  = req_tdata[IW-1:0];
   assign row_bits  = req_tdata[IW+RW-1:IW];
   assign req_tready = (state_ff == gf2mm_pkg::ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign idx_ok    = ({1'b0, load_idx} < DIM_MAX);
   assign a_we      = req_fire && idx_ok && (req_tuser == gf2mm_pkg::OP_LOAD_A);
   assign b_we      = req_fire && idx_ok && (req_tuser == gf2mm_pkg::OP_LOAD_B);
   assign col_mask  = {RW{1'b1}} >> (DW'(RW) - cols_ff);
   assign last_row  = (({1'b0, r_ff} + DW'(1)) == rows_ff);

   gf2mm_ram #(.WIDTH(RW), .DEPTH(MAX_DIM)) u_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (load_idx[AW-1:0]),
      .wdata (row_bits),
      .re    (a_re),
      .raddr (a_raddr),
      .rdata (a_q)
   );

   gf2mm_ram #(.WIDTH(RW), .DEPTH(MAX_DIM)) u_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (load_idx[AW-1:0]),
      .wdata (row_bits),
      .re    (b_re),
      .raddr (b_raddr),
      .rdata (b_q)
   );

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      inner_in     = inner_ff;
      cols_in      = cols_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      pk_in        = pk_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      a_re         = 1'b0;
      b_re         = 1'b0;
      a_raddr      = r_ff[AW-1:0];
      b_raddr      = k_ff[AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            gf2mm_pkg::CSR_ROWS_A:     rows_in  = gf2mm_pkg::clamp_dim(csr_wdata, DIM_MAX);
            gf2mm_pkg::CSR_INNER_SIZE: inner_in = gf2mm_pkg::clamp_dim(csr_wdata, DIM_MAX);
            gf2mm_pkg::CSR_COLS_B:     cols_in  = gf2mm_pkg::clamp_dim(csr_wdata, DIM_MAX);
            default: ;
         endcase
      end

      case (state_ff)
         gf2mm_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == gf2mm_pkg::OP_COMPUTE) begin
               r_in     = '0;
               state_in = gf2mm_pkg::ST_RD_A;
            end
         end
         gf2mm_pkg::ST_RD_A: begin
            a_re     = 1'b1;
            b_re     = 1'b1;
            b_raddr  = '0;
            k_in     = DW'(1);
            pk_in    = '0;
            acc_in   = '0;
            state_in = gf2mm_pkg::ST_ACC;
         end
         gf2mm_pkg::ST_ACC: begin
            acc_in = acc_ff ^ (a_q[pk_ff] ? b_q : '0);
            if (k_ff == inner_ff) begin
               state_in = gf2mm_pkg::ST_OUT;
            end else begin
               b_re  = 1'b1;
               pk_in = k_ff[IW-1:0];
               k_in  = k_ff + DW'(1);
            end
         end
         gf2mm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = r_ff;
               rsp_bits_in  = acc_ff & col_mask;
               rsp_last_in  = last_row;
               if (last_row) begin
                  state_in = gf2mm_pkg::ST_IDLE;
               end else begin
                  r_in     = r_ff + IW'(1);
                  state_in = gf2mm_pkg::ST_RD_A;
               end
            end
         end
         default: state_in = gf2mm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gf2mm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= DIM_MAX;
         inner_ff     <= DIM_MAX;
         cols_ff      <= DIM_MAX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         inner_ff     <= inner_in;
         cols_ff      <= cols_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      k_ff         <= k_in;
      pk_ff        <= pk_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(72 - IW - RW){1'b0}}, rsp_bits_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

   `GF2MM_ASSERT_NEXT(a_compute_start, clock, reset, req_fire && req_tuser == gf2mm_pkg::OP_COMPUTE, state_ff == gf2mm_pkg::ST_RD_A && r_ff == '0)
   `GF2MM_ASSERT_IMPL(a_k_range, clock, reset, state_ff == gf2mm_pkg::ST_ACC, k_ff != '0 && k_ff <= inner_ff)
   `GF2MM_ASSERT_IMPL(a_last_row, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_index_ff == IW'(rows_ff - DW'(1)))
   `GF2MM_ASSERT_IMPL(a_col_mask, clock, reset, rsp_valid_ff, (rsp_bits_ff & ~col_mask) == '0)

endmodule

// ----- hdl/gf2mm_ram.sv -----
module gf2mm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         waddr,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  re,
   input  logic [AW-1:0]         raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- tb/testbench.sv -----
module testbench;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 600;

   typedef struct {
      logic [5:0]  index;
      logic [63:0] bits;
      logic        last;
   } product_row_type;

   class gf2_product_board;
      logic [63:0]     a_rows [64];
      logic [63:0]     b_rows [64];
      logic [6:0]      dims [3];
      product_row_type expected_rows [$];
      int              errors;

      function new();
         for (int i = 0; i < 64; i++) begin
            a_rows[i] = '0;
            b_rows[i] = '0;
         end
         foreach (dims[i]) dims[i] = 7'd64;
         errors = 0;
      endfunction

      // zero counts as one, anything past 64 saturates
      function int eff_dim(logic [6:0] v);
         if (v == 7'd0) return 1;
         if (v > 7'd64) return 64;
         return int'(v);
      endfunction

      function void set_reg(logic [1:0] idx, logic [6:0] v);
         dims[idx] = v;
      endfunction

      function void note_item(logic [1:0] op, logic [5:0] index, logic [63:0] bits);
         int              nr;
         int              ni;
         int              nc;
         logic [63:0]     mask;
         logic [63:0]     acc;
         product_row_type row;
         case (op)
            gf2mm_pkg::OP_LOAD_A: a_rows[index] = bits;
            gf2mm_pkg::OP_LOAD_B: b_rows[index] = bits;
            gf2mm_pkg::OP_COMPUTE: begin
               nr = eff_dim(dims[gf2mm_pkg::CSR_ROWS_A]);
               ni = eff_dim(dims[gf2mm_pkg::CSR_INNER_SIZE]);
               nc = eff_dim(dims[gf2mm_pkg::CSR_COLS_B]);
               mask = (nc == 64) ? '1 : ((64'd1 << nc) - 64'd1);
               for (int r = 0; r < nr; r++) begin
                  acc = '0;
                  for (int k = 0; k < ni; k++) begin
                     if (a_rows[r][k]) acc ^= b_rows[k];
                  end
                  row.index = 6'(r);
                  row.bits = acc & mask;
                  row.last = (r == nr - 1);
                  expected_rows.push_back(row);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_row(logic [5:0] index, logic [63:0] bits, logic last);
         product_row_type want;
         if (expected_rows.size() == 0) begin
            $error("result row %0d arrived with no product pending", index);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         if (index !== want.index) begin
            $error("result_index expected %0d got %0d", want.index, index);
            errors++;
         end
         if (bits !== want.bits) begin
            $error("result_bits expected %h got %h", want.bits, bits);
            errors++;
         end
         if (last !== want.last) begin
            $error("last expected %0b got %0b", want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // load_idx[5:0], row_bits[69:6], zero pad
   logic [1:0]  req_tuser;   // op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // result_index[5:0], result_bits[69:6], zero pad
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [6:0]  csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;

   gf2_product_board board = new();

   gf2_matrix_multiply u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand_row();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0: w = '0;
         1: w = '1;
         2: w = 64'd1 << $urandom_range(63);
         3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
         default: ;
      endcase
      return w;
   endfunction

   // mostly small matrices; a few out-of-range and full-size settings
   function automatic logic [6:0] rand_dim();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return 7'($urandom_range(8, 1));
      if (pick < 85) return 7'($urandom_range(64, 9));
      if (pick < 92) return 7'd0;
      if (pick < 96) return 7'($urandom_range(127, 65));
      return 7'd64;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [5:0] index,
                            input logic [63:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, bits, index};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      board.note_item(op, index, bits);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic [6:0] rows, input logic [6:0] inner,
                            input logic [6:0] cols);
      write_reg(gf2mm_pkg::CSR_ROWS_A, rows);
      write_reg(gf2mm_pkg::CSR_INNER_SIZE, inner);
      write_reg(gf2mm_pkg::CSR_COLS_B, cols);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random_phase(input int count, input bit compute_first);
      int         nr;
      int         ni;
      int         sent;
      int         pick;
      logic [1:0] op;
      logic [5:0] index;
      nr = board.eff_dim(board.dims[gf2mm_pkg::CSR_ROWS_A]);
      ni = board.eff_dim(board.dims[gf2mm_pkg::CSR_INNER_SIZE]);
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (compute_first && sent == 0) pick = 0;
         if (pick < 12) op = gf2mm_pkg::OP_COMPUTE;
         else if (pick < 17) op = OP_UNUSED;
         else if (pick < 58) op = gf2mm_pkg::OP_LOAD_A;
         else op = gf2mm_pkg::OP_LOAD_B;
         if ($urandom_range(9) < 3) index = 6'($urandom_range(63));
         else if (op == gf2mm_pkg::OP_LOAD_B) index = 6'($urandom_range(ni - 1));
         else index = 6'($urandom_range(nr - 1));
         send_item(op, index, rand_row());
         if (op != OP_UNUSED) sent++;
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      hold_cycles = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_row(rsp_tdata[5:0], rsp_tdata[69:6], rsp_tlast);
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 11;
      recv_idle_pct = 46;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill both stores first so no product ever reads an unwritten row
      for (int i = 0; i < 64; i++) begin
         send_item(gf2mm_pkg::OP_LOAD_A, 6'(i), rand_row());
         send_item(gf2mm_pkg::OP_LOAD_B, 6'(i), rand_row());
      end

      // reset dimensions, full 64x64 product
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd0, '0);
      send_item(OP_UNUSED, 6'd0, '1);
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd63, '1);
      wait_idle();

      // zero dimensions act as one
      configure(7'd0, 7'd0, 7'd0);
      send_item(gf2mm_pkg::OP_LOAD_A, 6'd0, '1);
      send_item(gf2mm_pkg::OP_LOAD_B, 6'd0, '1);
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd0, '0);
      send_item(gf2mm_pkg::OP_LOAD_A, 6'd63, '0);
      send_item(gf2mm_pkg::OP_LOAD_B, 6'd63, '1);
      wait_idle();

      // oversized dimensions saturate
      configure(7'd127, 7'd127, 7'd127);
      send_item(gf2mm_pkg::OP_LOAD_A, 6'd63, 64'h8000_0000_0000_0000);
      send_item(gf2mm_pkg::OP_LOAD_B, 6'd0, 64'h5555_5555_5555_5555);
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd0, '0);
      wait_idle();

      configure(7'd64, 7'd1, 7'd64);
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd0, '0);
      wait_idle();

      configure(7'd2, 7'd64, 7'd1);
      send_item(gf2mm_pkg::OP_LOAD_A, 6'd1, '1);
      send_item(gf2mm_pkg::OP_COMPUTE, 6'd0, '0);

      for (int p = 0; p < 12; p++) begin
         wait_idle();
         if (p == 4) begin
            send_idle_pct = 46;
            recv_idle_pct = 11;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(rand_dim(), rand_dim(), rand_dim());
         // long rsp stall while items keep coming
         if (p == 1) hold_cycles = HOLD_OFF_CYCLES;
         run_random_phase(22, p == 1);
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
